// ----- rtl/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// sm3_pkg
// shared types, constants and bit functions of the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_PAD   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   typedef logic [31:0] word_type;

   localparam word_type T_LOW    = 32'h79CC4519;
   localparam word_type T_HIGH   = 32'h7A879D8A;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam word_type SM3_IV [8] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   // rotate left by 0..31
   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// ----- rtl/sm3_hash_engine.sv -----
// ----------------------------------------------------------------------------
// sm3_hash_engine
// sm3 hash (256-bit digest) over a stream of big-endian 32-bit words
// ----------------------------------------------------------------------------
// A message arrives one word per req transaction, first byte in bits 31..24.
// The final word carries last_word and a count of valid high bytes (0 to 4,
// larger counts read as 4); bytes past that count are ignored. A plain word is
// taken whenever the engine is idle. Every sixteenth word starts a compression
// of 64 rounds, one round per cycle on a single shared round unit with the
// message schedule expanded on the fly in a 16-word shift window; the engine
// holds req_stall high while it runs. After the last word the sequencer pushes
// the 0x80 byte if the last word was full, zero words and the 64-bit bit
// length one word per cycle outside compressions, runs one or two more
// compressions, then offers the digest as eight rsp transactions, index 0
// first, digest_last on the eighth. Once the eighth is taken the chaining
// value returns to the initial value and the next message may start. No input
// is taken while padding, compressing or returning the digest.
// ----------------------------------------------------------------------------
module sm3_hash_engine
   import sm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // message words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_msg_word,
   input  logic [2:0]  req_word_bytes,
   input  logic        req_last_word,
   // digest words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last
);

   state_type   state_ff,  state_in;
   word_type    chain_ff [8];      // chaining value
   word_type    chain_in [8];
   word_type    round_ff [8];      // working words a..h
   word_type    round_in [8];
   word_type    win_ff   [16];     // block buffer, then schedule window w[j..j+15]
   word_type    win_in   [16];
   logic [5:0]  ridx_ff,   ridx_in;     // round number
   logic [3:0]  count_ff,  count_in;    // words gathered in the block
   logic [63:0] bitlen_ff, bitlen_in;
   logic        pad_act_ff, pad_act_in; // message closing, padding in flight
   logic        need80_ff,  need80_in;  // 0x80 word still owed after a full last word
   logic        lenhi_ff,   lenhi_in;   // high length word already pushed
   logic [2:0]  oidx_ff,    oidx_in;    // digest word on offer

   logic        push_en;
   word_type    push_data;
   logic [2:0]  nbytes;
   word_type    last_data;

   // round unit signals
   word_type    ra, rb, rc, rd, re, rf, rg, rh;
   word_type    t_rot, a12, ss1, ss2, ff_v, gg_v, tt1, tt2, w_new;
   logic        early;

   // clamp the byte count and place the padding byte after the valid bytes
   always_comb begin
      nbytes = (req_word_bytes > 3'd4) ? 3'd4 : req_word_bytes;
      case (nbytes)
         3'd0:    last_data = {PAD_BYTE, 24'h0};
         3'd1:    last_data = {req_msg_word[31:24], PAD_BYTE, 16'h0};
         3'd2:    last_data = {req_msg_word[31:16], PAD_BYTE, 8'h0};
         3'd3:    last_data = {req_msg_word[31:8], PAD_BYTE};
         default: last_data = req_msg_word;
      endcase
   end

   // one sm3 round plus one step of the message expansion
   always_comb begin
      ra    = round_ff[0];
      rb    = round_ff[1];
      rc    = round_ff[2];
      rd    = round_ff[3];
      re    = round_ff[4];
      rf    = round_ff[5];
      rg    = round_ff[6];
      rh    = round_ff[7];
      early = (ridx_ff < 6'd16);
      t_rot = rotl(early ? T_LOW : T_HIGH, ridx_ff[4:0]);
      a12   = rotl(ra, 5'd12);
      ss1   = rotl(a12 + re + t_rot, 5'd7);
      ss2   = ss1 ^ a12;
      ff_v  = early ? (ra ^ rb ^ rc) : ((ra & rb) | (ra & rc) | (rb & rc));
      gg_v  = early ? (re ^ rf ^ rg) : ((re & rf) | (~re & rg));
      tt1   = ff_v + rd + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2   = gg_v + rh + ss1 + win_ff[0];
      w_new = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 5'd15))
            ^ rotl(win_ff[3], 5'd7) ^ win_ff[10];
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      chain_in   = chain_ff;
      round_in   = round_ff;
      win_in     = win_ff;
      ridx_in    = ridx_ff;
      count_in   = count_ff;
      bitlen_in  = bitlen_ff;
      pad_act_in = pad_act_ff;
      need80_in  = need80_ff;
      lenhi_in   = lenhi_ff;
      oidx_in    = oidx_ff;
      push_en    = 1'b0;
      push_data  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               push_en = 1'b1;
               if (!req_last_word) begin
                  push_data = req_msg_word;
                  bitlen_in = bitlen_ff + 64'd32;
               end else begin
                  push_data  = last_data;
                  bitlen_in  = bitlen_ff + {58'd0, nbytes, 3'd0};
                  pad_act_in = 1'b1;
                  lenhi_in   = 1'b0;
                  need80_in  = (nbytes == 3'd4);
                  state_in   = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            round_in[0] = tt1;
            round_in[1] = ra;
            round_in[2] = rotl(rb, 5'd9);
            round_in[3] = rc;
            round_in[4] = perm0(tt2);
            round_in[5] = re;
            round_in[6] = rotl(rf, 5'd19);
            round_in[7] = rg;
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = w_new;
            ridx_in    = ridx_ff + 6'd1;
            if (ridx_ff == 6'd63) begin
               // fold the last round straight into the chaining value
               for (int i = 0; i < 8; i++) begin
                  chain_in[i] = chain_ff[i] ^ round_in[i];
               end
               ridx_in = '0;
               if (!pad_act_ff) begin
                  state_in = ST_IDLE;
               end else if (lenhi_ff) begin
                  state_in = ST_OUT;
                  oidx_in  = '0;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (need80_ff) begin
               push_data = {PAD_BYTE, 24'h0};
               need80_in = 1'b0;
            end else if (count_ff == 4'd14) begin
               push_data = bitlen_ff[63:32];
               lenhi_in  = 1'b1;
            end else if (lenhi_ff) begin
               push_data = bitlen_ff[31:0];
            end else begin
               push_data = '0;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  // back to the initial value for the next message
                  chain_in   = SM3_IV;
                  bitlen_in  = '0;
                  pad_act_in = 1'b0;
                  lenhi_in   = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // word into the block; the sixteenth starts a compression
      if (push_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = push_data;
         if (count_ff == 4'd15) begin
            count_in = '0;
            round_in = chain_ff;
            ridx_in  = '0;
            state_in = ST_ROUND;
         end else begin
            count_in = count_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chain_ff   <= SM3_IV;
         ridx_ff    <= '0;
         count_ff   <= '0;
         bitlen_ff  <= '0;
         pad_act_ff <= 1'b0;
         need80_ff  <= 1'b0;
         lenhi_ff   <= 1'b0;
         oidx_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         chain_ff   <= chain_in;
         ridx_ff    <= ridx_in;
         count_ff   <= count_in;
         bitlen_ff  <= bitlen_in;
         pad_act_ff <= pad_act_in;
         need80_ff  <= need80_in;
         lenhi_ff   <= lenhi_in;
         oidx_ff    <= oidx_in;
      end
   end

   // block window and working words carry no control meaning
   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      round_ff <= round_in;
   end

   // only an idle engine takes a word
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_digest_word  = chain_ff[oidx_ff];
   assign rsp_digest_index = oidx_ff;
   assign rsp_digest_last  = (oidx_ff == 3'd7);

`ifndef SYNTHESIS
   // rounds only count while compressing
   a_ridx_round: assert property (@(posedge clock) disable iff (reset)
      (ridx_ff != 6'd0) |-> (state_ff == ST_ROUND))
      else $error("round counter running outside a compression");

   // the block count stays empty throughout a compression
   a_count_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (count_ff == 4'd0))
      else $error("words counted during a compression");

   // never take a word while a digest is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("input open while digest pending");

   // the final digest transaction restarts the chaining value and length
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_digest_last)
         |=> (bitlen_ff == 64'd0 && chain_ff[0] == SM3_IV[0] && !pad_act_ff))
      else $error("engine not restarted after digest");

   // the high length word is only pushed once padding is under way
   a_lenhi_pad: assert property (@(posedge clock) disable iff (reset)
      lenhi_ff |-> pad_act_ff)
      else $error("length word pushed outside padding");
`endif

endmodule

// ----- dv/tb_sm3_hash_engine.sv -----
// ----------------------------------------------------------------------------
// tb_sm3_hash_engine
// self-checking testbench for the sm3 hash engine
// ----------------------------------------------------------------------------
// Messages are streamed in as word transactions on the req channel. Each
// accepted word is folded into a behavioural sm3 model held in the bench,
// which queues the eight digest words that the final word of a message
// brings. Each rsp transaction is compared with the oldest queued digest word.
// Known vectors and padding corner cases come first, then random messages,
// a stretch with no idling, a long hold-off on the digest side while
// further messages are offered, and a last run of random messages.
// ----------------------------------------------------------------------------
module tb_sm3_hash_engine
   import sm3_pkg::*;
();

   // one digest word as the block should return it
   typedef struct packed {
      word_type   digest_word;
      logic [2:0] digest_index;
      logic       digest_last;
   } digest_entry_type;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [31:0] req_msg_word   = '0;
   logic [2:0]  req_word_bytes = '0;
   logic        req_last_word  = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_digest_index;
   logic        rsp_digest_last;

   // digest words still owed by the block, oldest first
   digest_entry_type digest_queue [$];

   // shadow of the hash state
   word_type    shadow_chain [8];
   word_type    shadow_block [16];
   int unsigned shadow_fill;
   logic [63:0] shadow_bits;

   int unsigned error_count     = 0;
   bit          no_idle         = 1'b0;
   int unsigned rsp_hold_cycles = 0;

   sm3_hash_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_msg_word     (req_msg_word),
      .req_word_bytes   (req_word_bytes),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // generous wall for the whole run, far beyond the slowest legal run
   initial begin
      #1000000;
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // behavioural sm3
   // ------------------------------------------------------------------

   // rotate left, amount taken modulo 32
   function automatic word_type rol(input word_type x, input int unsigned n);
      int unsigned k;
      k = n % 32;
      if (k == 0) return x;
      return (x << k) | (x >> (32 - k));
   endfunction

   function automatic word_type mix_p0(input word_type x);
      return x ^ rol(x, 9) ^ rol(x, 17);
   endfunction

   function automatic word_type mix_p1(input word_type x);
      return x ^ rol(x, 15) ^ rol(x, 23);
   endfunction

   function automatic void compress_shadow();
      word_type w [68];
      word_type r [8];
      word_type t, a12, ss1, ss2, ff, gg, tt1, tt2;
      for (int j = 0; j < 16; j++) w[j] = shadow_block[j];
      // message expansion
      for (int j = 16; j < 68; j++)
         w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
      for (int j = 0; j < 8; j++) r[j] = shadow_chain[j];
      for (int j = 0; j < 64; j++) begin
         t   = (j < 16) ? T_LOW : T_HIGH;
         a12 = rol(r[0], 12);
         ss1 = rol(a12 + r[4] + rol(t, j), 7);
         ss2 = ss1 ^ a12;
         ff  = (j < 16) ? (r[0] ^ r[1] ^ r[2])
                        : ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
         gg  = (j < 16) ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
         tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + r[7] + ss1 + w[j];
         r[3] = r[2];
         r[2] = rol(r[1], 9);
         r[1] = r[0];
         r[0] = tt1;
         r[7] = r[6];
         r[6] = rol(r[5], 19);
         r[5] = r[4];
         r[4] = mix_p0(tt2);
      end
      for (int j = 0; j < 8; j++) shadow_chain[j] ^= r[j];
   endfunction

   function automatic void absorb_word(input word_type w);
      shadow_block[shadow_fill] = w;
      shadow_fill++;
      if (shadow_fill == 16) begin
         shadow_fill = 0;
         compress_shadow();
      end
   endfunction

   function automatic void restart_shadow();
      for (int j = 0; j < 8; j++) shadow_chain[j] = SM3_IV[j];
      shadow_fill = 0;
      shadow_bits = '0;
   endfunction

   // fold one accepted word into the shadow, queueing the digest on a last word
   function automatic void predict_digest(input word_type w, input logic [2:0] nbytes,
                                          input logic is_last);
      int unsigned      nb;
      word_type         keep;
      digest_entry_type entry;
      if (!is_last) begin
         absorb_word(w);
         shadow_bits += 64'd32;
         return;
      end
      // byte counts above four read as a full word
      nb = (nbytes > 3'd4) ? 4 : nbytes;
      shadow_bits += 64'(8 * nb);
      if (nb == 4) begin
         absorb_word(w);
         absorb_word({PAD_BYTE, 24'h0});
      end else begin
         keep = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
         absorb_word((w & keep) | (word_type'(PAD_BYTE) << (24 - 8 * nb)));
      end
      while (shadow_fill != 14) absorb_word(32'h0);
      absorb_word(shadow_bits[63:32]);
      absorb_word(shadow_bits[31:0]);
      for (int i = 0; i < 8; i++) begin
         entry.digest_word  = shadow_chain[i];
         entry.digest_index = 3'(i);
         entry.digest_last  = (i == 7);
         digest_queue.push_back(entry);
      end
      restart_shadow();
   endfunction

   initial restart_shadow();

   // ------------------------------------------------------------------
   // digest side: stall pattern and checking of every rsp transaction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      digest_entry_type exp_e;
      bit               hold;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected digest transaction: word %h index %0d last %0b",
                        rsp_digest_word, rsp_digest_index, rsp_digest_last);
         end else begin
            exp_e = digest_queue.pop_front();
            if (rsp_digest_word !== exp_e.digest_word ||
                rsp_digest_index !== exp_e.digest_index ||
                rsp_digest_last !== exp_e.digest_last) begin
               error_count++;
               if (error_count <= 10)
                  $display("digest mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                           exp_e.digest_word, exp_e.digest_index, exp_e.digest_last,
                           rsp_digest_word, rsp_digest_index, rsp_digest_last);
            end
         end
      end
      // long hold-off counted here, otherwise random stalls unless quiet
      if (rsp_hold_cycles > 0) begin
         hold = 1'b1;
         rsp_hold_cycles--;
      end else if (no_idle) begin
         hold = 1'b0;
      end else begin
         hold = ($urandom_range(0, 99) < 32);
      end
      rsp_stall <= hold;
   end

   // ------------------------------------------------------------------
   // message side
   // ------------------------------------------------------------------

   // offer one word transaction and wait for its acceptance
   task automatic send_word(input word_type w, input logic [2:0] nbytes, input logic is_last);
      // idle cycle by cycle at random
      while (!no_idle && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_msg_word   <= w;
      req_word_bytes <= nbytes;
      req_last_word  <= is_last;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_digest(w, nbytes, is_last);
   endtask

   // random word content, with the all-zero and all-one extremes well represented
   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // message lengths biased around the padding boundary of a block
   function automatic int unsigned pick_length();
      case ($urandom_range(0, 7))
         0, 1:    return $urandom_range(13, 17);
         2:       return $urandom_range(28, 40);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   task automatic send_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_word(pick_word(), 3'($urandom_range(0, 7)), i == len - 1);
   endtask

   // sender stands back until the block has returned everything owed
   task automatic wait_for_digests();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic test_directed_vectors();
      // empty message, only the pad byte
      send_word(32'h1234_5678, 3'd0, 1'b1);
      // "abc", the published test vector
      send_word(32'h6162_6300, 3'd3, 1'b1);
      // full last word, pad byte lands in the next word
      send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
      // byte count too large, read as four
      send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
      // unused low bytes must be masked off
      send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
      send_word(32'hDEAD_BEEF, 3'd2, 1'b1);
      // thirteen words and a full last word push padding into a second block
      for (int i = 0; i < 13; i++) send_word((i % 2) ? 32'h0 : 32'hFFFF_FFFF, 3'd5, 1'b0);
      send_word(32'hA5A5_5A5A, 3'd4, 1'b1);
      wait_for_digests();
   endtask

   task automatic test_random_messages(input int unsigned target);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < target) begin
         len = pick_length();
         send_message(len);
         sent += len;
         // now and then the sender pauses until the digests are all back
         if ($urandom_range(0, 9) == 0) wait_for_digests();
      end
   endtask

   task automatic test_quiet_stretch(input int unsigned target);
      int unsigned sent;
      int unsigned len;
      wait_for_digests();
      no_idle = 1'b1;
      sent = 0;
      while (sent < target) begin
         len = $urandom_range(1, 17);
         send_message(len);
         sent += len;
      end
      wait_for_digests();
      no_idle = 1'b0;
   endtask

   task automatic test_output_holdoff();
      wait_for_digests();
      // digest side blocked long enough for the engine to stall its input
      rsp_hold_cycles = 400;
      send_message(3);
      send_message(2);
      send_message(5);
      send_message(16);
      wait_for_digests();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_directed_vectors();
      test_random_messages(150);
      test_quiet_stretch(30);
      test_output_holdoff();
      test_random_messages(30);

      wait_for_digests();
      // let any stray transaction show itself
      repeat (100) @(posedge clock);
      if (error_count == 0 && digest_queue.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/sm3_pkg.sv
rtl/sm3_hash_engine.sv
dv/tb_sm3_hash_engine.sv
